/* hdl/otbs_pkg.sv */
// Shared types and constants for the oscillator trim binary search unit.
package otbs_pkg;

  localparam int unsigned LenW  = 16;
  localparam int unsigned TrimW = 8;
  localparam int unsigned StepW = 7;
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  localparam logic [LenW-1:0]  TargetReset   = 16'd1827;
  localparam logic [LenW-1:0]  NoDeviation   = 16'd9999;
  localparam logic [StepW-1:0] FirstStep     = 7'd64;
  localparam logic [TrimW-1:0] FirstTrial    = 8'd64;
  localparam logic [TrimW-1:0] HighFirstTrial = 8'd192;

  // Register index taken from paddr[2]
  localparam logic RegTarget = 1'b0;

  // Input action codes
  localparam logic ActStart   = 1'b0;
  localparam logic ActMeasure = 1'b1;

  // One result beat
  typedef struct packed {
    logic [TrimW-1:0] trim_value;
    logic             is_final;
    logic             was_ignored;
  } result_t;

  // Search state visible to the top level for checking
  typedef struct packed {
    logic             searching;
    logic             region;
    logic [StepW-1:0] step;
  } status_t;

endpackage

/* hdl/otbs_apb_regs.sv */
// APB configuration register block holding the target frame length.
module otbs_apb_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [otbs_pkg::AddrW-1:0] paddr,
  input  logic [otbs_pkg::DataW-1:0] pwdata,
  output logic [otbs_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output logic [otbs_pkg::LenW-1:0]  target
);
  import otbs_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == RegTarget);

  // Target register write
  always_ff @(posedge clk) begin
    if (rst) begin
      target <= TargetReset;
    end else if (wr_en) begin
      target <= pwdata[LenW-1:0];
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    if (paddr[2] == RegTarget) begin
      prdata = {{(DataW-LenW){1'b0}}, target};
    end
  end

endmodule

/* hdl/otbs_search_core.sv */
// Search state and the single-step update for one staged item.
module otbs_search_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic                      action,
  input  logic [otbs_pkg::LenW-1:0] meas,
  input  logic [otbs_pkg::LenW-1:0] target,
  output otbs_pkg::result_t         result,
  output otbs_pkg::status_t         status
);
  import otbs_pkg::*;

  logic             searching, searching_next;
  logic             region, region_next;
  logic [StepW-1:0] step, step_next;
  logic [TrimW-1:0] trial, trial_next;
  logic [TrimW-1:0] best_trim, best_trim_next;
  logic [LenW-1:0]  best_dev, best_dev_next;
  logic             below;
  logic [LenW-1:0]  dev;
  logic [TrimW-1:0] half_step;

  // Absolute deviation from target
  assign below     = meas < target;
  assign dev       = below ? (target - meas) : (meas - target);
  assign half_step = {1'b0, step >> 1};

  always_comb begin
    searching_next = searching;
    region_next    = region;
    step_next      = step;
    trial_next     = trial;
    best_trim_next = best_trim;
    best_dev_next  = best_dev;
    result         = '0;
    if (action == ActStart) begin
      searching_next    = 1'b1;
      region_next       = 1'b0;
      step_next         = FirstStep;
      best_trim_next    = '0;
      best_dev_next     = NoDeviation;
      trial_next        = FirstTrial;
      result.trim_value = FirstTrial;
    end else if (!searching) begin
      result.was_ignored = 1'b1;
    end else begin
      // keep strictly better trial
      if (dev < best_dev) begin
        best_dev_next  = dev;
        best_trim_next = trial;
      end
      if (step > 7'd1) begin
        step_next  = step >> 1;
        trial_next = below ? (trial + half_step) : (trial - half_step);
        result.trim_value = trial_next;
      end else if (!region) begin
        region_next       = 1'b1;
        step_next         = FirstStep;
        trial_next        = HighFirstTrial;
        result.trim_value = HighFirstTrial;
      end else begin
        searching_next    = 1'b0;
        result.trim_value = best_trim_next;
        result.is_final   = 1'b1;
      end
    end
  end

  // State update on each staged beat
  always_ff @(posedge clk) begin
    if (rst) begin
      searching <= 1'b0;
      region    <= 1'b0;
      step      <= FirstStep;
      trial     <= '0;
      best_trim <= '0;
      best_dev  <= NoDeviation;
    end else if (advance) begin
      searching <= searching_next;
      region    <= region_next;
      step      <= step_next;
      trial     <= trial_next;
      best_trim <= best_trim_next;
      best_dev  <= best_dev_next;
    end
  end

  assign status = '{searching: searching, region: region, step: step};

endmodule

/* hdl/oscillator_trim_binary_search_unit.sv */
// Top level of the oscillator trim binary search unit.
//
// Input channel (meas_valid / meas_stall): one beat carries action and
// measured_length. Action start resets the search and yields trial 64;
// action measure scores the last trial and yields the next one. After the
// fourteenth measurement the best trim comes out with is_final set. A
// measurement with no search running yields was_ignored and changes nothing.
// Output channel (result_valid / result_stall): one result beat per input
// beat, in order: trim_value, is_final, was_ignored.
// Path: a beat passes through the input stage, then the result register.
// Throughput: one beat per cycle while the receiver does not stall, set by
// the state update between the stages.
// A stalled result holds; the input stage still takes one more beat, and
// meas_stall rises only when both stages are full and the receiver stalls.
// Reset (rst, synchronous) empties both stages, idles the search and sets
// the target frame length register (APB address 0) to 1827.
module oscillator_trim_binary_search_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [otbs_pkg::AddrW-1:0] paddr,
  input  logic [otbs_pkg::DataW-1:0] pwdata,
  output logic [otbs_pkg::DataW-1:0] prdata,
  output logic                       pready,
  input  logic                       meas_valid,
  output logic                       meas_stall,
  input  logic                       action,
  input  logic [otbs_pkg::LenW-1:0]  measured_length,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [otbs_pkg::TrimW-1:0] trim_value,
  output logic                       is_final,
  output logic                       was_ignored
);
  import otbs_pkg::*;

  logic            stg_valid;
  logic            stg_action;
  logic [LenW-1:0] stg_meas;
  logic [LenW-1:0] target;
  logic            out_free;
  logic            advance;
  logic            accept;
  result_t         step_result;
  status_t         status;

  otbs_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .target  (target)
  );

  otbs_search_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .action  (stg_action),
    .meas    (stg_meas),
    .target  (target),
    .result  (step_result),
    .status  (status)
  );

  // Handshake control
  assign out_free   = !result_valid || !result_stall;
  assign advance    = stg_valid && out_free;
  assign meas_stall = stg_valid && !out_free;
  assign accept     = meas_valid && !meas_stall;

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (accept) begin
      stg_valid <= 1'b1;
    end else if (advance) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_action <= action;
      stg_meas   <= measured_length;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      trim_value  <= step_result.trim_value;
      is_final    <= step_result.is_final;
      was_ignored <= step_result.was_ignored;
    end
  end

  // Checks
  a_step_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(status.step))
    else $error("step size is not a power of two");

  a_ignored_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && was_ignored |-> !is_final && trim_value == '0)
    else $error("ignored beat carries a trim value or final flag");

  a_final_idles: assert property (@(posedge clk) disable iff (rst)
    advance && step_result.is_final |=> !status.searching)
    else $error("search still running after final result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !meas_stall)
    else $error("pipeline not empty after reset");

endmodule

/* tb/sv/trim_search_checker.sv */
// Checker for the oscillator trim search unit: predicts each result beat and compares it.
module trim_search_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [otbs_pkg::AddrW-1:0] paddr,
  input  logic [otbs_pkg::DataW-1:0] pwdata,
  input  logic                       meas_valid,
  input  logic                       meas_stall,
  input  logic                       action,
  input  logic [otbs_pkg::LenW-1:0]  measured_length,
  input  logic                       result_valid,
  input  logic                       result_stall,
  input  logic [otbs_pkg::TrimW-1:0] trim_value,
  input  logic                       is_final,
  input  logic                       was_ignored,
  output int                         fail_count,
  output int                         pending,
  output int                         results_checked,
  output int                         finals_seen,
  output int                         ignored_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import otbs_pkg::*;

  // Shadow copy of the search state and the target register
  logic             srch_active;
  logic             srch_region;
  logic [StepW-1:0] srch_step;
  logic [TrimW-1:0] srch_trial;
  logic [TrimW-1:0] best_trim;
  logic [LenW-1:0]  best_dev;
  logic [LenW-1:0]  target_len;

  result_t expected_trims[$];
  int n_fail, n_checked, n_final, n_ignored;

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      n_fail++;
    end
  endtask

  // Advance the shadow search by one input beat and return the result it yields
  task automatic predict_trim_result(input logic act, input logic [LenW-1:0] len,
                                     output result_t r);
    logic [LenW-1:0] dev;
    r = '0;
    if (act == ActStart) begin
      // start (also mid-search): fresh search, first trial of the low region
      srch_active = 1'b1;
      srch_region = 1'b0;
      srch_step   = FirstStep;
      best_trim   = '0;
      best_dev    = NoDeviation;
      srch_trial  = FirstTrial;
      r.trim_value = srch_trial;
    end else if (!srch_active) begin
      r.was_ignored = 1'b1;
    end else begin
      dev = (len >= target_len) ? len - target_len : target_len - len;
      // strictly smaller only: on a tie the earlier trial stays
      if (dev < best_dev) begin
        best_dev  = dev;
        best_trim = srch_trial;
      end
      if (srch_step > 1) begin
        srch_step = srch_step >> 1;
        if (len < target_len) srch_trial = srch_trial + {1'b0, srch_step};
        else srch_trial = srch_trial - {1'b0, srch_step};
        r.trim_value = srch_trial;
      end else if (!srch_region) begin
        srch_region = 1'b1;
        srch_step   = FirstStep;
        srch_trial  = HighFirstTrial;
        r.trim_value = srch_trial;
      end else begin
        srch_active = 1'b0;
        r.trim_value = best_trim;
        r.is_final   = 1'b1;
      end
    end
  endtask

  // Watch both channels and the register port at every rising edge
  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      srch_active = 1'b0;
      srch_region = 1'b0;
      srch_step   = FirstStep;
      srch_trial  = '0;
      best_trim   = '0;
      best_dev    = NoDeviation;
      target_len  = TargetReset;
      expected_trims.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == RegTarget)
        target_len = pwdata[LenW-1:0];
      // result beat: compare against the oldest expectation
      if (result_valid && !result_stall) begin
        if (expected_trims.size() == 0) begin
          $display("%0t ns: unexpected result beat, got trim %0d final %0b ignored %0b",
                   $time, trim_value, is_final, was_ignored);
          n_fail++;
        end else begin
          want = expected_trims.pop_front();
          check_field("trim_value", want.trim_value, trim_value);
          check_field("is_final", want.is_final, is_final);
          check_field("was_ignored", want.was_ignored, was_ignored);
        end
        n_checked++;
        if (is_final) n_final++;
        if (was_ignored) n_ignored++;
      end
      // input beat: predict its result
      if (meas_valid && !meas_stall) begin
        predict_trim_result(action, measured_length, want);
        expected_trims.push_back(want);
      end
    end
    fail_count      <= n_fail;
    pending         <= expected_trims.size();
    results_checked <= n_checked;
    finals_seen     <= n_final;
    ignored_seen    <= n_ignored;
  end

endmodule

/* tb/sv/testbench.sv */
// Top of the trim search testbench: clock, reset, register writes, beat stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import otbs_pkg::*;

  localparam int TrialsPerSearch = 14;
  localparam int LongHold        = 400;
  localparam int StallLimit      = 2000;
  localparam int PhaseItems      = 120;
  localparam int NumPhases       = 8;

  logic             clk;
  logic             rst = 1'b1;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             meas_valid = 1'b0;
  logic             meas_stall;
  logic             action = ActStart;
  logic [LenW-1:0]  measured_length = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  logic [TrimW-1:0] trim_value;
  logic             is_final;
  logic             was_ignored;

  int fail_count, pending, results_checked, finals_seen, ignored_seen;

  // Stimulus bookkeeping
  int      beats_sent;
  int      phase_beats;
  int      burst_left = 1;
  bit      gap_on;
  bit      in_search;
  int      cur_target = TargetReset;
  int      tie_dev;
  int      stall_mode;
  bit      hold_request;
  int      rx_phase;
  int      idle_cycles;
  int      phase_targets[NumPhases];

  oscillator_trim_binary_search_unit dut (.*);

  trim_search_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: ends the run when no beat or register access moves for too long
  always @(posedge clk) begin
    if (rst || (meas_valid && !meas_stall) || (result_valid && !result_stall) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("Watchdog: no progress for %0d cycles, %0d results outstanding",
               StallLimit, pending);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stall pattern per mode, or one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      rx_phase++;
      if (hold_request) begin
        result_stall <= 1'b1;
        repeat (LongHold) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        case (stall_mode)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 3) == 0);
          2: result_stall <= $urandom_range(0, 1);
          default: result_stall <= (rx_phase % 7) < 3;
        endcase
      end
    end
  end

  // Register write: setup cycle, then access cycle until pready
  task automatic apb_write(input logic [LenW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegTarget, 2'b00};
    pwdata  <= {{(DataW-LenW){1'b0}}, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_target = value;
  endtask

  // Offer one input beat; sender works in bursts, with random gaps when gap_on is set
  task automatic offer(input logic act, input logic [LenW-1:0] len);
    meas_valid      <= 1'b1;
    action          <= act;
    measured_length <= len;
    do @(posedge clk); while (meas_stall);
    beats_sent++;
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      if (gap_on) begin
        meas_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  endtask

  // Sender pauses until every outstanding result has come back
  task automatic wait_for_results();
    meas_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Frame length near the target, exactly on it, on a tie, an extreme, or anything
  function automatic logic [LenW-1:0] pick_length();
    int v;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 25) return LenW'($urandom_range(0, 65535));
    if (sel < 65) v = cur_target + int'($urandom_range(0, 600)) - 300;
    else if (sel < 75) v = cur_target;
    else if (sel < 90) v = $urandom_range(0, 1) ? cur_target + tie_dev : cur_target - tie_dev;
    else v = $urandom_range(0, 1) ? 65535 : 0;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[LenW-1:0];
  endfunction

  // A start beat followed by n measurements
  task automatic run_search(input int n_meas);
    tie_dev = $urandom_range(0, 400);
    offer(ActStart, LenW'($urandom_range(0, 65535)));
    in_search = 1'b1;
    for (int i = 0; i < n_meas; i++) offer(ActMeasure, pick_length());
    if (n_meas == TrialsPerSearch) in_search = 1'b0;
    phase_beats += n_meas + 1;
  endtask

  initial begin
    int sel;
    phase_targets = '{TargetReset, 0, 65535, 1, $urandom_range(0, 65535), 65534,
                      $urandom_range(500, 4000), TargetReset};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: measurements while idle at both length extremes
    gap_on = 1'b1;
    offer(ActMeasure, '0);
    offer(ActMeasure, '1);
    // a search where no trial comes within the no-deviation bound
    offer(ActStart, '0);
    for (int i = 0; i < TrialsPerSearch; i++) offer(ActMeasure, '1);
    // measurement after the final result is ignored
    offer(ActMeasure, LenW'(cur_target));
    // exact hit, below-target step, then a restart mid-search
    offer(ActStart, '1);
    offer(ActMeasure, LenW'(cur_target));
    offer(ActMeasure, '0);
    offer(ActStart, '0);
    in_search = 1'b1;

    // Random phases, one target setting each
    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        wait_for_results();
        apb_write(LenW'(phase_targets[p]));
      end
      phase_beats = 0;
      if (p == 2 || p == 5) hold_request = 1'b1;
      while (phase_beats < PhaseItems) begin
        stall_mode = $urandom_range(0, 3);
        gap_on = ($urandom_range(0, 3) != 0);
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
          run_search(TrialsPerSearch);
        end else if (sel < 90 || in_search) begin
          run_search($urandom_range(0, TrialsPerSearch - 1));
        end else begin
          // noise: stray measurements with no search running
          repeat ($urandom_range(1, 3)) offer(ActMeasure, LenW'($urandom_range(0, 65535)));
        end
      end
    end

    wait_for_results();
    repeat (8) @(negedge clk);
    $display("Run covered %0d input beats over %0d target settings (0, 65535 among them).",
             beats_sent, NumPhases);
    $display("%0d result beats checked: %0d final, %0d flagged as ignored.",
             results_checked, finals_seen, ignored_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
